// ===== hw/rtl/interval_timer_multiplexer_top_assert.svh =====
// Assertion macros for the interval timer multiplexer.
`ifndef INTERVAL_TIMER_MULTIPLEXER_TOP_ASSERT_SVH
`define INTERVAL_TIMER_MULTIPLEXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ITM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ITM_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ITM_ASSERT_IMP(label, clk, rst, a, c)
`define ITM_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hw/rtl/itm_pkg.sv =====
package itm_pkg;
  localparam int unsigned LIMIT_W = 22;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam int unsigned RATE_W = 11;
  localparam int unsigned MIN_INSTALL_DELAY = 5;
  localparam int unsigned RATE_CAP = 1024;

  typedef enum logic [2:0] {
    MODE_TICK = 3'd0, MODE_INSTALL = 3'd1, MODE_UNINSTALL = 3'd2,
    MODE_ENABLE = 3'd3, MODE_DISABLE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_USED = 2'd1, ST_NOT_USED = 2'd2
  } status_t;
endpackage

// ===== hw/rtl/itm_ram.sv =====
module itm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/interval_timer_multiplexer_top.sv =====
// Interval timer multiplexer: one hardware timer shared by SLOTS slots.
// Enable/disable and errors go from decode straight to the output; a tick walks all slots;
// a rate change runs a (DELAY_WIDTH)-step divider per installed slot. One item at a time.
// Reset (rst, synchronous, active high) clears used/active marks, min
// delay and sets the timer stopped; slot memories need no clearing.
`include "interval_timer_multiplexer_top_assert.svh"
module interval_timer_multiplexer_top #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned DELAY_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // mode[2:0], slot[6:3], delay[30:7], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // fire_mask[15:0], hw_rate[26:16],
                                // timer_irq_enabled[27], status[29:28], zero fill
);
  import itm_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TREAD, S_TWRITE, S_UNMIN_RD, S_UNMIN, S_RL_RD,
    S_RL_DIV, S_RL_WR, S_OUT
  } state_t;

  state_t state;
  logic [2:0]  mode;
  logic [3:0]  slot_in;
  logic [23:0] delay_in;
  logic [SLOTS-1:0] used, active;
  logic [DELAY_WIDTH-1:0] min_delay;
  logic stopped;
  logic [CW-1:0] idx;        // walk counter
  logic [15:0] fire;
  logic [1:0]  status;
  logic single;              // reload only the addressed slot
  logic [DELAY_WIDTH-1:0] min_acc;
  logic any;
  // divider
  logic [DELAY_WIDTH-1:0] dividend, rem_q;
  logic [RATE_W-1:0] divisor;
  logic [$clog2(DELAY_WIDTH+1)-1:0] dcnt;
  logic [DELAY_WIDTH:0] rem;

  // memories
  logic dl_we, lc_we;
  logic [SW-1:0] dl_wa, lc_wa, rd_a;
  logic [DELAY_WIDTH-1:0] dl_wd, dl_rd;
  logic [2*LIMIT_W-1:0] lc_wd, lc_rd;

  itm_ram #(.WIDTH(DELAY_WIDTH), .DEPTH(SLOTS)) u_delay (
    .clk, .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(rd_a), .rdata(dl_rd));
  // limit in the upper half, count in the lower half
  itm_ram #(.WIDTH(2*LIMIT_W), .DEPTH(SLOTS)) u_lc (
    .clk, .we(lc_we), .waddr(lc_wa), .wdata(lc_wd), .raddr(rd_a), .rdata(lc_rd));

  logic [RATE_W-1:0] rate;
  assign rate = (min_delay < DELAY_WIDTH'(RATE_CAP)) ? RATE_W'(min_delay)
                                                     : RATE_W'(RATE_CAP);

  logic [SW-1:0] s_idx;
  logic valid_slot;
  assign s_idx = SW'(slot_in);
  assign valid_slot = 32'(slot_in) < SLOTS;

  // saturated, clamped delay
  logic [DELAY_WIDTH-1:0] dsat;
  always_comb begin
    if (32'(delay_in) > 32'((64'd1 << DELAY_WIDTH) - 64'd1)) dsat = '1;
    else dsat = DELAY_WIDTH'(delay_in);
    if (dsat < DELAY_WIDTH'(MIN_INSTALL_DELAY)) dsat = DELAY_WIDTH'(MIN_INSTALL_DELAY);
  end

  // one restoring-division step
  logic [DELAY_WIDTH:0] rem_sh;
  logic rem_ge;
  assign rem_sh = {rem[DELAY_WIDTH-1:0], dividend[DELAY_WIDTH-1]};
  assign rem_ge = rem_sh >= (DELAY_WIDTH+1)'(divisor);

  logic [LIMIT_W-1:0] lim;
  always_comb begin
    if (divisor == '0) lim = LIMIT_MAX;
    else if (32'(rem_q) > 32'(LIMIT_MAX)) lim = LIMIT_MAX;
    else lim = LIMIT_W'(rem_q);
  end

  logic [LIMIT_W-1:0] cnt_inc;
  assign cnt_inc = lc_rd[LIMIT_W-1:0] + 1'b1;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    dl_we = 1'b0; dl_wa = s_idx; dl_wd = dsat;
    lc_we = 1'b0; lc_wa = idx[SW-1:0]; lc_wd = '0;
    rd_a = idx[SW-1:0];
    case (state)
      S_DECODE: if (mode == MODE_INSTALL && valid_slot && !used[s_idx]) dl_we = 1'b1;
      S_TWRITE: begin
        lc_we = used[idx[SW-1:0]] && active[idx[SW-1:0]];
        lc_wd = {lc_rd[2*LIMIT_W-1:LIMIT_W],
                 (cnt_inc == lc_rd[2*LIMIT_W-1:LIMIT_W]) ? LIMIT_W'(0) : cnt_inc};
      end
      S_RL_WR: begin
        lc_we = 1'b1;
        lc_wd = {lim, lim - 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; used <= '0; active <= '0; min_delay <= '0;
      stopped <= 1'b1; m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode <= s_tdata[2:0]; slot_in <= s_tdata[6:3]; delay_in <= s_tdata[30:7];
            fire <= '0; status <= ST_OK; idx <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_OUT;
          if (mode == MODE_TICK) state <= S_TREAD;
          else if (mode >= MODE_INSTALL && mode <= MODE_DISABLE && !valid_slot)
            status <= ST_NOT_USED;
          else if (mode == MODE_INSTALL) begin
            if (used[s_idx]) status <= ST_USED;
            else begin
              used[s_idx] <= 1'b1; active[s_idx] <= 1'b0;
              if (stopped || min_delay > dsat) begin
                stopped <= 1'b0; min_delay <= dsat; single <= 1'b0; idx <= '0;
              end else begin
                single <= 1'b1; idx <= CW'(s_idx);
              end
              state <= S_RL_RD;
            end
          end else if (mode == MODE_UNINSTALL) begin
            if (!used[s_idx]) status <= ST_NOT_USED;
            else begin
              used[s_idx] <= 1'b0; active[s_idx] <= 1'b0;
              any <= 1'b0; min_acc <= '0; state <= S_UNMIN_RD;
            end
          end else if (mode == MODE_ENABLE || mode == MODE_DISABLE) begin
            if (!used[s_idx]) status <= ST_NOT_USED;
            else active[s_idx] <= (mode == MODE_ENABLE);
          end
        end
        S_TREAD: state <= S_TWRITE;
        S_TWRITE: begin
          if (used[idx[SW-1:0]] && active[idx[SW-1:0]] &&
              cnt_inc == lc_rd[2*LIMIT_W-1:LIMIT_W] && 32'(idx) < 32'd16)
            fire[4'(idx)] <= 1'b1;
          if (idx == CW'(SLOTS-1)) state <= S_OUT;
          else begin idx <= idx + 1'b1; state <= S_TREAD; end
        end
        S_UNMIN_RD: state <= S_UNMIN;
        S_UNMIN: begin
          if (used[idx[SW-1:0]] && (!any || dl_rd < min_acc)) begin
            min_acc <= dl_rd; any <= 1'b1;
          end
          if (idx == CW'(SLOTS-1)) begin
            idx <= '0; single <= 1'b0; state <= S_OUT;
            if (!(any || used[idx[SW-1:0]])) begin
              stopped <= 1'b1; min_delay <= '0;
            end else begin
              logic [DELAY_WIDTH-1:0] m;
              m = (used[idx[SW-1:0]] && (!any || dl_rd < min_acc)) ? dl_rd : min_acc;
              if (stopped || m != min_delay) begin
                stopped <= 1'b0; min_delay <= m; state <= S_RL_RD;
              end
            end
          end else begin idx <= idx + 1'b1; state <= S_UNMIN_RD; end
        end
        S_RL_RD: begin
          if (!used[idx[SW-1:0]]) begin
            if (single || idx == CW'(SLOTS-1)) state <= S_OUT;
            else idx <= idx + 1'b1;
          end else state <= S_RL_DIV;
          dcnt <= '0; rem <= '0; rem_q <= '0; divisor <= rate;
        end
        S_RL_DIV: begin
          if (dcnt == '0) dividend <= dl_rd;
          else begin
            rem <= rem_ge ? rem_sh - (DELAY_WIDTH+1)'(divisor) : rem_sh;
            rem_q <= {rem_q[DELAY_WIDTH-2:0], rem_ge};
            dividend <= dividend << 1;
          end
          if (dcnt == ($clog2(DELAY_WIDTH+1))'(DELAY_WIDTH)) state <= S_RL_WR;
          dcnt <= dcnt + 1'b1;
        end
        S_RL_WR: begin
          if (single || idx == CW'(SLOTS-1)) state <= S_OUT;
          else begin idx <= idx + 1'b1; state <= S_RL_RD; end
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {2'b0, status, !stopped,
                        stopped ? RATE_W'(0) : rate, fire};
          end else if (m_tready) begin
            m_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ITM_ASSERT_IMP(a_stop_zero, clk, rst, stopped, min_delay == '0)
  `ITM_ASSERT_IMP(a_ready_idle, clk, rst, s_tready, !m_tvalid)
  `ITM_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itm_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned MAX_REPORTS = 10;

  // Result item as it travels on m_tdata.
  typedef struct packed {
    logic [15:0] fire_mask;
    logic [10:0] hw_rate;
    logic        irq_en;
    logic [1:0]  status;
  } timer_result_t;

  // Predictor of the timer table plus the queue of results it expects.
  class timer_scoreboard;
    bit              used[NUM_SLOTS];
    bit              active[NUM_SLOTS];
    bit [23:0]       delay_q[NUM_SLOTS];
    bit [21:0]       count_q[NUM_SLOTS];
    bit [21:0]       limit_q[NUM_SLOTS];
    bit [23:0]       min_delay;
    bit              stopped;
    timer_result_t   pending[$];
    int unsigned     errors;

    function new();
      errors = 0;
      min_delay = '0;
      stopped = 1'b1;
      foreach (used[i]) begin
        used[i] = 1'b0;
        active[i] = 1'b0;
      end
    endfunction

    function bit [23:0] base_rate();
      return (min_delay < RATE_CAP) ? min_delay : 24'(RATE_CAP);
    endfunction

    function void load_limit(int i);
      bit [23:0] rate;
      bit [23:0] quot;
      bit [21:0] lim;
      rate = base_rate();
      if (rate == 0) begin
        lim = LIMIT_MAX;
      end else begin
        quot = delay_q[i] / rate;
        lim = (quot > 24'(LIMIT_MAX)) ? LIMIT_MAX : quot[21:0];
      end
      limit_q[i] = lim;
      count_q[i] = lim - 22'd1;
    endfunction

    function void reload_all();
      for (int i = 0; i < NUM_SLOTS; i++)
        if (used[i]) load_limit(i);
    endfunction

    // Apply one accepted input item and queue its result.
    function void note_input(logic [2:0] mode, logic [3:0] slot, logic [23:0] delay);
      timer_result_t r;
      bit [21:0] c;
      bit [23:0] d;
      bit [23:0] m;
      bit        any;
      bit [23:0] rate_now;
      r = '0;
      case (mode)
        MODE_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used[i] && active[i]) begin
              c = count_q[i] + 22'd1;
              if (c == limit_q[i]) begin
                c = '0;
                r.fire_mask[i] = 1'b1;
              end
              count_q[i] = c;
            end
          end
        end
        MODE_INSTALL: begin
          if (used[slot]) begin
            r.status = ST_USED;
          end else begin
            d = (delay < MIN_INSTALL_DELAY) ? 24'(MIN_INSTALL_DELAY) : delay;
            delay_q[slot] = d;
            active[slot] = 1'b0;
            used[slot] = 1'b1;
            if (stopped || min_delay > d) begin
              stopped = 1'b0;
              min_delay = d;
              reload_all();
            end else begin
              load_limit(slot);
            end
          end
        end
        MODE_UNINSTALL: begin
          if (!used[slot]) begin
            r.status = ST_NOT_USED;
          end else begin
            used[slot] = 1'b0;
            active[slot] = 1'b0;
            any = 1'b0;
            m = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (used[i] && (!any || delay_q[i] < m)) begin
                m = delay_q[i];
                any = 1'b1;
              end
            end
            if (!any) begin
              stopped = 1'b1;
              min_delay = '0;
            end else if (m != min_delay) begin
              min_delay = m;
              reload_all();
            end
          end
        end
        MODE_ENABLE, MODE_DISABLE: begin
          if (!used[slot]) r.status = ST_NOT_USED;
          else active[slot] = (mode == MODE_ENABLE);
        end
        default: ;
      endcase
      rate_now = base_rate();
      r.hw_rate = stopped ? 11'd0 : rate_now[10:0];
      r.irq_en = !stopped;
      pending.push_back(r);
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending.size() == 0) begin
        report_error($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.fire_mask !== want.fire_mask)
        report_error($sformatf("fire_mask exp %h got %h", want.fire_mask, got.fire_mask));
      if (got.hw_rate !== want.hw_rate)
        report_error($sformatf("hw_rate exp %0d got %0d", want.hw_rate,
                               got.hw_rate));
      if (got.irq_en !== want.irq_en)
        report_error($sformatf("irq_enabled exp %b got %b", want.irq_en, got.irq_en));
      if (got.status !== want.status)
        report_error($sformatf("status exp %0d got %0d", want.status, got.status));
    endfunction

    function void report_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // mode[2:0], slot[6:3], delay[30:7], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // fire_mask[15:0], hw_rate[26:16], irq_enabled[27],
                          // status[29:28], zero fill

  timer_scoreboard sb;
  int unsigned     idle_cycles;
  int unsigned     burst_left;
  bit              stall_on;

  interval_timer_multiplexer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall on its own pattern - long open stretches, then bursts of
  // random back-pressure. Check every result item accepted at this edge.
  initial begin
    m_tready = 1'b0;
    stall_on = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(timer_result_t'({m_tdata[15:0], m_tdata[26:16],
                                          m_tdata[27], m_tdata[29:28]}));
      end
      if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
      m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Send one item; hold it until accepted, then note it in the predictor.
  // Between bursts, drop valid for a random gap.
  task automatic send_item(logic [2:0] mode, logic [3:0] slot, logic [23:0] delay);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, delay, slot, mode};
    do @(posedge clk); while (!s_tready);
    sb.note_input(mode, slot, delay);
    burst_left--;
  endtask

  // Hold off the sender until every expected result is back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_delay();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 6));
      1: return 24'($urandom_range(7, 64));
      2: return 24'($urandom_range(500, 1500));
      3: return 24'($urandom);
      4: return 24'hFFFFFF;
      default: return 24'($urandom_range(5, 300));
    endcase
  endfunction

  // Mostly well-formed: install, enable, run ticks, occasionally tear down.
  task automatic random_phase(int unsigned items);
    int unsigned sent;
    int unsigned pick;
    logic [3:0]  s;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      s = 4'($urandom);
      if (pick < 50) begin
        send_item(MODE_TICK, 4'($urandom), 24'($urandom));
      end else if (pick < 65) begin
        send_item(MODE_INSTALL, s, rand_delay());
      end else if (pick < 78) begin
        send_item(MODE_ENABLE, s, 24'($urandom));
      end else if (pick < 85) begin
        send_item(MODE_DISABLE, s, 24'($urandom));
      end else if (pick < 95) begin
        send_item(MODE_UNINSTALL, s, 24'($urandom));
      end else begin
        send_item(3'($urandom_range(5, 7)), s, 24'($urandom));
      end
      sent++;
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a tick and bad items on an empty table, then the special cases in turn.
    send_item(MODE_TICK, 4'd0, 24'd0);
    send_item(MODE_UNINSTALL, 4'd3, 24'd0);
    send_item(MODE_ENABLE, 4'd3, 24'd0);
    send_item(MODE_DISABLE, 4'd3, 24'd0);
    send_item(3'd7, 4'd15, 24'hFFFFFF);
    send_item(MODE_INSTALL, 4'd0, 24'd0);          // raised to the minimum delay
    send_item(MODE_INSTALL, 4'd0, 24'd100);        // already installed
    send_item(MODE_INSTALL, 4'd15, 24'hFFFFFF);    // limit well above the rate
    send_item(MODE_INSTALL, 4'd7, 24'd2048);
    send_item(MODE_ENABLE, 4'd0, 24'd0);
    send_item(MODE_ENABLE, 4'd15, 24'd0);
    send_item(MODE_ENABLE, 4'd7, 24'd0);
    repeat (4) send_item(MODE_TICK, 4'd0, 24'd0);
    send_item(MODE_UNINSTALL, 4'd0, 24'd0);        // minimum moves to 2048, capped
    repeat (3) send_item(MODE_TICK, 4'd0, 24'd0);
    send_item(MODE_DISABLE, 4'd7, 24'd0);
    send_item(MODE_TICK, 4'd0, 24'd0);
    send_item(MODE_UNINSTALL, 4'd7, 24'd0);
    send_item(MODE_UNINSTALL, 4'd15, 24'd0);       // last slot: timer stops
    send_item(3'd5, 4'd0, 24'd0);
    send_item(3'd6, 4'd8, 24'h800000);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    random_phase(RANDOM_ITEMS / 2);
    wait_drained();
    random_phase(RANDOM_ITEMS - RANDOM_ITEMS / 2);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
